FILE: src/xbrpm_pkg.sv
// Shared constants, command/status types and a modular helper for the XOR basis rank unit.
`default_nettype none
package xbrpm_pkg;

   // Item and result field widths
   localparam int VALUE_BITS = 20;
   localparam int COUNT_W    = 16;
   localparam int TOTAL_W    = 32;
   localparam int POWER_W    = 30;
   localparam int RANK_W     = 5;

   // Basis row index width
   localparam int BIT_IDX_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   // Modular arithmetic
   localparam logic [POWER_W-1:0] MOD_PRIME = POWER_W'(998244353);
   localparam int MUL_IDX_W = $clog2(POWER_W);
   localparam int EXP_IDX_W = $clog2(TOTAL_W);

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;   // latch an accepted beat, add its count
      logic ins_step;    // one bit position of basis insertion
      logic prep;        // form exponent, clear basis, start power
      logic sq_step;     // one bit of the serial modular square
      logic dbl;         // optional doubling, advance exponent bit
      logic out_load;    // move result into output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic ins_done;    // insertion finishes on this step
      logic item_last;   // latched item closes the set
      logic sq_last;     // final bit of the current square
      logic exp_last;    // exponent bit zero is being handled
      logic out_free;    // output register can take a result
   } status_type;

   // Return (2 * r + (add_en ? a : 0)) mod MOD_PRIME, with r and a already reduced
   function automatic logic [POWER_W-1:0] mod_dbl_add(
      input logic [POWER_W-1:0] r,
      input logic [POWER_W-1:0] a,
      input logic               add_en
   );
      logic [POWER_W:0] t;
      logic [POWER_W:0] u;
      t = {r, 1'b0};
      if (t >= {1'b0, MOD_PRIME}) begin
         t = t - {1'b0, MOD_PRIME};
      end
      u = t + (add_en ? {1'b0, a} : '0);
      if (u >= {1'b0, MOD_PRIME}) begin
         u = u - {1'b0, MOD_PRIME};
      end
      return u[POWER_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: src/xbrpm_if.sv
// Valid/ready channel interfaces for the item and result sides.
`default_nettype none
interface xbrpm_req_if;
   logic                             valid;
   logic                             ready;
   logic [xbrpm_pkg::VALUE_BITS-1:0] item_value;
   logic [xbrpm_pkg::COUNT_W-1:0]    item_count;
   logic                             last_item;

   modport source (output valid, output item_value, output item_count, output last_item,
                   input ready);
   modport sink   (input valid, input item_value, input item_count, input last_item,
                   output ready);
endinterface

interface xbrpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [xbrpm_pkg::POWER_W-1:0] power_result;
   logic [xbrpm_pkg::RANK_W-1:0]  basis_rank;

   modport source (output valid, output power_result, output basis_rank, input ready);
   modport sink   (input valid, input power_result, input basis_rank, output ready);
endinterface
`default_nettype wire

FILE: src/xbrpm_ctrl.sv
// Sequencer for insertion, serial modular exponentiation and result hand-off.
`default_nettype none
module xbrpm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire xbrpm_pkg::status_type status,
   output xbrpm_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INSERT = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_DOUBLE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a beat only while the sequencer is idle
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.ins_step = 1'b1;
            if (status.ins_done) begin
               state_in = status.item_last ? ST_PREP : ST_IDLE;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            if (status.sq_last) begin
               state_in = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            cmd.dbl  = 1'b1;
            state_in = status.exp_last ? ST_FINISH : ST_SQUARE;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/xbrpm_dp.sv
// Datapath: XOR basis rows, count total, serial modular power and output register.
`default_nettype none
module xbrpm_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire xbrpm_pkg::cmd_type                  cmd,
   output xbrpm_pkg::status_type                    status,
   input  wire logic [xbrpm_pkg::VALUE_BITS-1:0]    item_value,
   input  wire logic [xbrpm_pkg::COUNT_W-1:0]       item_count,
   input  wire logic                                last_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [xbrpm_pkg::POWER_W-1:0]            power_result,
   output logic [xbrpm_pkg::RANK_W-1:0]             basis_rank
);

   localparam int VB = xbrpm_pkg::VALUE_BITS;
   localparam int PW = xbrpm_pkg::POWER_W;
   localparam int TW = xbrpm_pkg::TOTAL_W;
   localparam int RW = xbrpm_pkg::RANK_W;
   localparam int BW = xbrpm_pkg::BIT_IDX_W;
   localparam int MW = xbrpm_pkg::MUL_IDX_W;
   localparam int EW = xbrpm_pkg::EXP_IDX_W;

   // Insertion state
   logic [VB-1:0] val_ff;
   logic [BW-1:0] bit_ff;
   logic          last_ff;
   logic [VB-1:0] basis_ff [VB];
   logic [RW-1:0] rank_ff;
   logic [TW-1:0] total_ff;

   // Power state
   logic [TW-1:0] exp_ff;
   logic [EW-1:0] ebit_ff;
   logic [PW-1:0] x_ff;
   logic [PW-1:0] r_ff;
   logic [MW-1:0] mbit_ff;
   logic [RW-1:0] hold_rank_ff;

   // Output register
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_power_ff;
   logic [RW-1:0] rsp_rank_ff;

   logic [VB-1:0] row_sel;
   logic          take_row;
   logic [TW:0]   total_sum;
   logic [PW-1:0] r_next;
   logic [PW-1:0] x_dbl;
   logic          out_free;

   assign row_sel   = basis_ff[bit_ff];
   assign take_row  = val_ff[bit_ff] && (row_sel == '0);
   assign total_sum = {1'b0, total_ff} + {{(TW + 1 - xbrpm_pkg::COUNT_W){1'b0}}, item_count};
   assign r_next    = xbrpm_pkg::mod_dbl_add(r_ff, x_ff, x_ff[mbit_ff]);
   assign x_dbl     = xbrpm_pkg::mod_dbl_add(x_ff, '0, 1'b0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status           = '0;
      status.ins_done  = take_row || (bit_ff == '0);
      status.item_last = last_ff;
      status.sq_last   = (mbit_ff == '0);
      status.exp_last  = (ebit_ff == '0);
      status.out_free  = out_free;
   end

   // Item latch and insertion walk, top bit down
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         val_ff  <= item_value;
         bit_ff  <= BW'(VB - 1);
         last_ff <= last_item;
      end else if (cmd.ins_step) begin
         if (val_ff[bit_ff] && !take_row) begin
            val_ff <= val_ff ^ row_sel;
         end
         if (bit_ff != '0) begin
            bit_ff <= bit_ff - 1'b1;
         end
      end
   end

   // Basis rows, rank and saturating count total
   always_ff @(posedge clock) begin
      if (reset || cmd.prep) begin
         for (int i = 0; i < VB; i++) begin
            basis_ff[i] <= '0;
         end
         rank_ff  <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.load_item) begin
            total_ff <= total_sum[TW] ? '1 : total_sum[TW-1:0];
         end
         if (cmd.ins_step && take_row) begin
            basis_ff[bit_ff] <= val_ff;
            rank_ff          <= rank_ff + 1'b1;
         end
      end
   end

   // Left-to-right square and multiply: serial square, then optional doubling
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         exp_ff       <= (total_ff >= {{(TW - RW){1'b0}}, rank_ff}) ?
                         total_ff - {{(TW - RW){1'b0}}, rank_ff} : '0;
         hold_rank_ff <= rank_ff;
         ebit_ff      <= EW'(TW - 1);
         x_ff         <= PW'(1);
         r_ff         <= '0;
         mbit_ff      <= MW'(PW - 1);
      end else if (cmd.sq_step) begin
         r_ff    <= r_next;
         mbit_ff <= mbit_ff - 1'b1;
         if (mbit_ff == '0) begin
            x_ff <= r_next;
         end
      end else if (cmd.dbl) begin
         if (exp_ff[ebit_ff]) begin
            x_ff <= x_dbl;
         end
         r_ff    <= '0;
         mbit_ff <= MW'(PW - 1);
         ebit_ff <= ebit_ff - 1'b1;
      end
   end

   // Hold the result until the receiver takes the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_power_ff <= x_ff;
         rsp_rank_ff  <= hold_rank_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign power_result = rsp_power_ff;
   assign basis_rank   = rsp_rank_ff;

endmodule
`default_nettype wire

FILE: src/xor_basis_rank_power_mod_unit.sv
// Top level of the GF(2) basis rank unit with modular power of two.
//
// Usage: send a set of values on req_chan, one beat per value with its
// multiplicity in item_count and last_item set on the final beat. Each value
// is reduced into an XOR basis, one bit position per cycle from the top bit
// down, until it is placed or bit zero is done; except after the last beat,
// req_chan.ready returns in the cycle after insertion ends, so a new beat
// waits for the previous one. On the last beat the unit forms total - rank
// (zero if the rank is larger) and raises 2 to that power mod 998244353 with
// a bit-serial modular squarer: 32 exponent bits, each a serial square over
// the 30 operand bits and then a doubling step, before the result goes to
// rsp_chan with power_result and basis_rank. The basis and total are cleared
// as the power step starts, ready for the next set. The result sits in an
// output register, so new beats are accepted while it waits; a stalled
// receiver only holds back the end of the following set. Synchronous reset
// clears the basis, the total, the sequencer and the output valid.
`default_nettype none
module xor_basis_rank_power_mod_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   xbrpm_req_if.sink   req_chan,
   xbrpm_rsp_if.source rsp_chan
);

   xbrpm_pkg::cmd_type    cmd;
   xbrpm_pkg::status_type status;

   xbrpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xbrpm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .item_value   (req_chan.item_value),
      .item_count   (req_chan.item_count),
      .last_item    (req_chan.last_item),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .power_result (rsp_chan.power_result),
      .basis_rank   (rsp_chan.basis_rank)
   );

endmodule
`default_nettype wire

FILE: src/xbrpm_checker.sv
// Port-level checks for the basis rank unit, bound to the top level.
`default_nettype none
module xbrpm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [xbrpm_pkg::POWER_W-1:0] power_result,
   input wire logic [xbrpm_pkg::RANK_W-1:0]  basis_rank
);

   // Result is fully reduced
   a_power_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (power_result < xbrpm_pkg::MOD_PRIME))
      else $error("power_result not below modulus");

   // Rank never exceeds the row count
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (basis_rank <= xbrpm_pkg::RANK_W'(xbrpm_pkg::VALUE_BITS)))
      else $error("basis_rank above row count");

   // Ready is low in the cycle after an accepted beat, while insertion runs
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high right after accept");

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(power_result)
                                     && $stable(basis_rank)))
      else $error("stalled result changed");

endmodule

bind xor_basis_rank_power_mod_unit xbrpm_checker u_xbrpm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .power_result (rsp_chan.power_result),
   .basis_rank   (rsp_chan.basis_rank)
);
`default_nettype wire

FILE: bench/xor_basis_rank_power_mod_unit_tb.sv
// Self-checking testbench for the XOR basis rank and modular power-of-two unit.
`timescale 1ns / 1ps
module xor_basis_rank_power_mod_unit_tb;

   localparam int VALUE_BITS = xbrpm_pkg::VALUE_BITS;
   localparam int COUNT_W    = xbrpm_pkg::COUNT_W;
   localparam int TOTAL_W    = xbrpm_pkg::TOTAL_W;
   localparam int POWER_W    = xbrpm_pkg::POWER_W;
   localparam int RANK_W     = xbrpm_pkg::RANK_W;
   localparam logic [POWER_W-1:0] MOD_PRIME = xbrpm_pkg::MOD_PRIME;

   localparam int unsigned CYCLE_LIMIT = 8_000_000;
   localparam int unsigned DRAIN_CYCLES = 1100;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned CALM_ITEMS = 100;

   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic [RANK_W-1:0]  rank;
   } set_answer_type;

   logic clock;
   logic reset;

   xbrpm_req_if req_chan ();
   xbrpm_rsp_if rsp_chan ();

   xor_basis_rank_power_mod_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: the basis rows and the running multiplicity sum
   logic [VALUE_BITS-1:0] basis_row [VALUE_BITS];
   logic [TOTAL_W-1:0]    set_total;
   set_answer_type        answers_awaited [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit          run_calm = 1'b0;
   bit          sender_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned stall_left = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      $display("mismatch at cycle %0d: %s, got %0d, want %0d",
               cycle_count, what, got, want);
   endtask

   // Square-and-multiply for 2^e mod the prime
   function automatic logic [POWER_W-1:0] two_pow_mod(input logic [TOTAL_W-1:0] e);
      longint unsigned prime;
      longint unsigned acc;
      longint unsigned sq;
      prime = longint'(MOD_PRIME);
      acc = 1;
      sq = 2;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * sq) % prime;
         end
         sq = (sq * sq) % prime;
         e = e >> 1;
      end
      return acc[POWER_W-1:0];
   endfunction

   function automatic void clear_set();
      for (int b = 0; b < VALUE_BITS; b++) begin
         basis_row[b] = '0;
      end
      set_total = '0;
   endfunction

   // Fold one accepted beat into the basis; on the last beat queue the answer
   function automatic void absorb_value(input logic [VALUE_BITS-1:0] value,
                                        input logic [COUNT_W-1:0] count,
                                        input logic last);
      logic [VALUE_BITS-1:0] v;
      logic [TOTAL_W:0]      sum;
      logic [TOTAL_W-1:0]    exponent;
      int unsigned           rank;
      set_answer_type        answer;
      v = value;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
         if (v[b]) begin
            if (basis_row[b] == '0) begin
               basis_row[b] = v;
               break;
            end
            v = v ^ basis_row[b];
         end
      end
      // Saturate the total rather than wrap
      sum = {1'b0, set_total} + {{(TOTAL_W + 1 - COUNT_W){1'b0}}, count};
      set_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      if (last) begin
         rank = 0;
         for (int b = 0; b < VALUE_BITS; b++) begin
            if (basis_row[b] != '0) begin
               rank++;
            end
         end
         exponent = (set_total >= rank) ? set_total - rank : '0;
         answer.power = two_pow_mod(exponent);
         answer.rank = RANK_W'(rank);
         answers_awaited = {answers_awaited, answer};
         clear_set();
      end
   endfunction

   // Drive one beat and hold it until the unit takes it
   task automatic send_beat(input logic [VALUE_BITS-1:0] value,
                            input logic [COUNT_W-1:0] count, input logic last);
      req_chan.valid <= 1'b1;
      req_chan.item_value <= value;
      req_chan.item_count <= count;
      req_chan.last_item <= last;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      absorb_value(value, count, last);
      items_sent++;
   endtask

   // Now and then drop valid for a random gap, unless calm or quiet
   task automatic sender_gap();
      if (!run_calm && !sender_quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_and_gap(input logic [VALUE_BITS-1:0] value,
                               input logic [COUNT_W-1:0] count, input logic last);
      send_beat(value, count, last);
      sender_gap();
   endtask

   // One-beat sets at the field extremes
   task automatic test_lone_values();
      send_and_gap('0, COUNT_W'(1), 1'b1);
      send_and_gap('1, '1, 1'b1);
      send_and_gap(VALUE_BITS'(1), COUNT_W'(1), 1'b1);
   endtask

   // Full rank, then a value in the span and a zero value
   task automatic test_full_rank_set();
      logic [VALUE_BITS-1:0] rows [VALUE_BITS];
      logic [VALUE_BITS-1:0] low_bits;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
         low_bits = VALUE_BITS'($urandom_range(0, (1 << b) - 1));
         rows[b] = (VALUE_BITS'(1) << b) | low_bits;
         send_and_gap(rows[b], (b % 2 == 0) ? '1 : COUNT_W'(1), 1'b0);
      end
      send_and_gap(rows[3] ^ rows[11] ^ rows[19], COUNT_W'(7), 1'b0);
      send_and_gap('0, COUNT_W'(1), 1'b1);
   endtask

   // Zero multiplicities leave the total below the rank
   task automatic test_zero_counts();
      send_and_gap(VALUE_BITS'(1), '0, 1'b0);
      send_and_gap(VALUE_BITS'(2), '0, 1'b0);
      send_and_gap(VALUE_BITS'(4), '0, 1'b1);
   endtask

   // Many maximum multiplicities in one set give a large exponent
   task automatic test_large_total();
      for (int i = 0; i < 23; i++) begin
         send_and_gap(VALUE_BITS'($urandom), '1, 1'b0);
      end
      send_and_gap(VALUE_BITS'($urandom), '1, 1'b1);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 63);
      if (r == 0) begin
         return '0;
      end else if (r < 8) begin
         return '1;
      end else if (r < 16) begin
         return COUNT_W'(1);
      end
      return COUNT_W'($urandom_range(1, 65535));
   endfunction

   // Random sets: full-width values, low-dimension spans, sparse values
   task automatic test_random_sets();
      logic [VALUE_BITS-1:0] gens [6];
      logic [VALUE_BITS-1:0] value;
      int unsigned           first_item;
      int unsigned           set_len;
      int unsigned           mode;
      int unsigned           gen_count;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         gen_count = $urandom_range(1, 6);
         for (int g = 0; g < 6; g++) begin
            gens[g] = VALUE_BITS'($urandom);
         end
         sender_quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_len; i++) begin
            if (items_sent - first_item >= RANDOM_ITEMS - CALM_ITEMS) begin
               run_calm = 1'b1;
            end
            case (mode)
               0: value = VALUE_BITS'($urandom);
               1: begin
                  value = '0;
                  for (int g = 0; g < gen_count; g++) begin
                     if ($urandom_range(0, 1) == 1) begin
                        value = value ^ gens[g];
                     end
                  end
               end
               default: begin
                  value = ($urandom_range(0, 3) == 0) ? '0
                        : VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
               end
            endcase
            send_and_gap(value, pick_count(), i == set_len - 1);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   // Result side ready: random stall bursts with quiet stretches
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!run_calm && !rsp_quiet && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) begin
         rsp_quiet <= !rsp_quiet;
      end
   end

   // Compare each result beat with the oldest awaited answer
   always @(posedge clock) begin : check_results
      set_answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (answers_awaited.size() == 0) begin
            report_mismatch("result with none awaited", rsp_chan.power_result, 0);
         end else begin
            want = answers_awaited.pop_front();
            if (rsp_chan.power_result !== want.power) begin
               report_mismatch("power_result", rsp_chan.power_result, want.power);
            end
            if (rsp_chan.basis_rank !== want.rank) begin
               report_mismatch("basis_rank", rsp_chan.basis_rank, want.rank);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.item_value = '0;
      req_chan.item_count = '0;
      req_chan.last_item = 1'b0;
      rsp_chan.ready = 1'b0;
      clear_set();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lone_values();
      test_full_rank_set();
      test_zero_counts();
      test_large_total();
      test_random_sets();

      // Drain, then allow for any stray result
      while (answers_awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
